### design/supply_temperature_monitor_smoother_assert.svh
// Assertion macros for the monitor RTL; stm_ctrl is the file that includes them.
// No dependencies; pulled in with an include by files that check their own logic.
`ifndef SUPPLY_TEMPERATURE_MONITOR_SMOOTHER_ASSERT_SVH
`define SUPPLY_TEMPERATURE_MONITOR_SMOOTHER_ASSERT_SVH

// same-cycle implication
`define STM_ASSERT_NOW(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication
`define STM_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### design/stm_pkg.sv
// Shared types and constants for the supply/temperature monitor smoother.
// No dependencies; used through scoped names by the top, stm_ctrl, stm_dp and the testbench.
`timescale 1ns / 1ps

package stm_pkg;

  localparam int RAW_W      = 12;
  localparam int LOAD_W     = 15;
  localparam int TEMP_OUT_W = 20;
  localparam int SUP_OUT_W  = 23;

  localparam int ALPHA_W = 16;
  localparam int AREF_W  = 13;
  localparam int V25_W   = 11;
  localparam int SLOPE_W = 14;
  localparam int IREF_W  = 11;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam int QUO_W  = 31;
  localparam int TFRAC  = 16;
  localparam int TCUR_W = 28;
  localparam int SCUR_W = 31;
  localparam int LCUR_W = 23;
  localparam int EMA_W  = 33;

  localparam logic signed [TCUR_W-1:0] TEMP_MIN_Q16  = -28'sd18284544;
  localparam logic signed [TCUR_W-1:0] TEMP_MAX_Q16  = 28'sd68222976;
  localparam logic signed [TCUR_W-1:0] TEMP_BIAS_Q16 = 28'sd1638400;
  localparam logic [SCUR_W-1:0]        SUPPLY_MAX_Q8 = 31'd1268467200;
  localparam logic [LOAD_W-1:0]        LOAD_MAX_Q8   = 15'd25600;

  localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd13107;
  localparam logic [AREF_W-1:0]  AREF_RST  = 13'd3300;
  localparam logic [V25_W-1:0]   V25_RST   = 11'd760;
  localparam logic [SLOPE_W-1:0] SLOPE_RST = 14'd2500;
  localparam logic [IREF_W-1:0]  IREF_RST  = 11'd1210;

  localparam logic signed [TCUR_W-1:0] TACC_RST = 28'sd1638400;
  localparam logic [SCUR_W-1:0]        SACC_RST = 31'd844800;
  localparam logic [LCUR_W-1:0]        LACC_RST = 23'd655360;

  typedef enum logic [2:0] {
    REG_ALPHA = 3'd0,
    REG_AREF  = 3'd1,
    REG_V25   = 3'd2,
    REG_SLOPE = 3'd3,
    REG_IREF  = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DSTART,
    ST_DIV,
    ST_SAMPLE,
    ST_EMA_T,
    ST_EMA_S,
    ST_EMA_L,
    ST_OUT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    EMA_TEMP,
    EMA_SUP,
    EMA_LOAD
  } ema_sel_t;

  typedef struct packed {
    logic     capture;
    logic     mul1;
    logic     mul2;
    logic     div_start;
    logic     sample;
    logic     ema_en;
    ema_sel_t ema_sel;
    logic     load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

endpackage

### design/supply_temperature_monitor_smoother.sv
// Requests are taken only while idle; in_stall stays high until the result is loaded out.
// Steps: capture, multiply, then the two 31-step restoring dividers (temperature and supply)
// side by side, sample, the shared EMA for temperature, supply and load in turn, and handoff.
// Reset (synchronous, rst_n low): registers to defaults, averages to 25 C,
// 3300 mV and 10 percent; no request in flight, no result pending.
`timescale 1ns / 1ps

module supply_temperature_monitor_smoother #(
  parameter int ADC_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [stm_pkg::CFG_ADDR_W-1:0]        paddr,
  input  logic [stm_pkg::CFG_DATA_W-1:0]        pwdata,
  output logic [stm_pkg::CFG_DATA_W-1:0]        prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [stm_pkg::RAW_W-1:0]             in_raw_temp,
  input  logic [stm_pkg::RAW_W-1:0]             in_raw_ref,
  input  logic [stm_pkg::LOAD_W-1:0]            in_load_sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [stm_pkg::TEMP_OUT_W-1:0] out_temp_average,
  output logic [stm_pkg::SUP_OUT_W-1:0]         out_supply_average_mv,
  output logic [stm_pkg::LOAD_W-1:0]            out_load_average,
  output logic                                  out_ref_was_zero
);

  localparam int DW = stm_pkg::CFG_DATA_W;

  logic [stm_pkg::ALPHA_W-1:0] alpha_r;
  logic [stm_pkg::AREF_W-1:0]  aref_r;
  logic [stm_pkg::V25_W-1:0]   v25_r;
  logic [stm_pkg::SLOPE_W-1:0] slope_r;
  logic [stm_pkg::IREF_W-1:0]  iref_r;

  stm_pkg::reg_idx_t  reg_idx;
  logic               wr_en;
  stm_pkg::ctrl_cmd_t cmd;
  stm_pkg::dp_stat_t  stat;

  assign reg_idx = stm_pkg::reg_idx_t'(paddr[stm_pkg::CFG_ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= stm_pkg::ALPHA_RST;
      aref_r  <= stm_pkg::AREF_RST;
      v25_r   <= stm_pkg::V25_RST;
      slope_r <= stm_pkg::SLOPE_RST;
      iref_r  <= stm_pkg::IREF_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        stm_pkg::REG_ALPHA: alpha_r <= pwdata[stm_pkg::ALPHA_W-1:0];
        stm_pkg::REG_AREF:  aref_r  <= pwdata[stm_pkg::AREF_W-1:0];
        stm_pkg::REG_V25:   v25_r   <= pwdata[stm_pkg::V25_W-1:0];
        stm_pkg::REG_SLOPE: slope_r <= pwdata[stm_pkg::SLOPE_W-1:0];
        stm_pkg::REG_IREF:  iref_r  <= pwdata[stm_pkg::IREF_W-1:0];
        default:            alpha_r <= alpha_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      stm_pkg::REG_ALPHA: prdata = DW'(alpha_r);
      stm_pkg::REG_AREF:  prdata = DW'(aref_r);
      stm_pkg::REG_V25:   prdata = DW'(v25_r);
      stm_pkg::REG_SLOPE: prdata = DW'(slope_r);
      stm_pkg::REG_IREF:  prdata = DW'(iref_r);
      default:            prdata = '0;
    endcase
  end

  stm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  stm_dp #(.ADC_BITS(ADC_BITS)) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .cfg_alpha             (alpha_r),
    .cfg_aref              (aref_r),
    .cfg_v25               (v25_r),
    .cfg_slope             (slope_r),
    .cfg_iref              (iref_r),
    .in_raw_temp           (in_raw_temp),
    .in_raw_ref            (in_raw_ref),
    .in_load_sample        (in_load_sample),
    .out_temp_average      (out_temp_average),
    .out_supply_average_mv (out_supply_average_mv),
    .out_load_average      (out_load_average),
    .out_ref_was_zero      (out_ref_was_zero)
  );

endmodule

### design/stm_div.sv
// Restoring divider, one quotient bit per cycle, with overflow detect.
// No dependencies; instanced by stm_dp.
`timescale 1ns / 1ps

module stm_div #(
  parameter int VW = 26,
  parameter int QW = 31
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [QW+VW-1:0] dividend,
  input  logic [VW-1:0]    divisor,
  output logic             done,
  output logic             ovf,
  output logic             rem_nz,
  output logic [QW-1:0]    quo
);

  localparam int CW = $clog2(QW + 1);

  logic [VW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic          ovf_r, ovf_nxt;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fit;

  always_comb begin
    trial    = {rem_r, quo_r[QW-1]};
    diff     = trial - {1'b0, dvs_r};
    fit      = (trial >= {1'b0, dvs_r});
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    ovf_nxt  = ovf_r;
    if (start) begin
      rem_nxt  = dividend[QW+VW-1:QW];
      quo_nxt  = dividend[QW-1:0];
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(QW);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      ovf_nxt  = (dividend[QW+VW-1:QW] >= divisor);
    end else if (busy_r) begin
      rem_nxt = fit ? diff[VW-1:0] : trial[VW-1:0];
      quo_nxt = {quo_r[QW-2:0], fit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    ovf_r <= ovf_nxt;
  end

  assign done   = done_r;
  assign ovf    = ovf_r;
  assign rem_nz = |rem_r;
  assign quo    = quo_r;

endmodule

### design/stm_dp.sv
// Datapath: sensor conversion products, two dividers, shared EMA unit, result regs.
// Depends on stm_pkg and stm_div; driven by stm_ctrl commands.
`timescale 1ns / 1ps

module stm_dp #(
  parameter int ADC_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  stm_pkg::ctrl_cmd_t                   cmd,
  output stm_pkg::dp_stat_t                    stat,
  input  logic [stm_pkg::ALPHA_W-1:0]          cfg_alpha,
  input  logic [stm_pkg::AREF_W-1:0]           cfg_aref,
  input  logic [stm_pkg::V25_W-1:0]            cfg_v25,
  input  logic [stm_pkg::SLOPE_W-1:0]          cfg_slope,
  input  logic [stm_pkg::IREF_W-1:0]           cfg_iref,
  input  logic [stm_pkg::RAW_W-1:0]            in_raw_temp,
  input  logic [stm_pkg::RAW_W-1:0]            in_raw_ref,
  input  logic [stm_pkg::LOAD_W-1:0]           in_load_sample,
  output logic signed [stm_pkg::TEMP_OUT_W-1:0] out_temp_average,
  output logic [stm_pkg::SUP_OUT_W-1:0]        out_supply_average_mv,
  output logic [stm_pkg::LOAD_W-1:0]           out_load_average,
  output logic                                 out_ref_was_zero
);

  localparam int RAW_W  = stm_pkg::RAW_W;
  localparam int QUO_W  = stm_pkg::QUO_W;
  localparam int EMA_W  = stm_pkg::EMA_W;
  localparam int TCUR_W = stm_pkg::TCUR_W;
  localparam int SCUR_W = stm_pkg::SCUR_W;
  localparam int LCUR_W = stm_pkg::LCUR_W;
  localparam int AL_W   = stm_pkg::ALPHA_W;

  localparam int P1_W    = RAW_W + stm_pkg::AREF_W;
  localparam int P1K_W   = P1_W + 10;
  localparam int V25K_W  = stm_pkg::V25_W + 10 + ADC_BITS;
  localparam int NUM_W   = ((P1K_W > V25K_W) ? P1K_W : V25K_W) + 1;
  localparam int MAG_W   = NUM_W - 1;
  localparam int DEN_W   = stm_pkg::SLOPE_W + ADC_BITS;
  localparam int TDIV_W  = QUO_W + DEN_W;
  localparam int SNUM_W  = stm_pkg::IREF_W + ADC_BITS + 8;
  localparam int SDIV_W  = QUO_W + RAW_W;
  localparam int TS_W    = QUO_W + 3;
  localparam int PROD_W  = EMA_W + AL_W + 2;
  localparam int SUM_W   = PROD_W + 1;
  localparam int V25_K_INT = 1000 * ((1 << ADC_BITS) - 1);

  localparam logic [ADC_BITS-1:0] ADC_MAX = {ADC_BITS{1'b1}};
  localparam logic [NUM_W-1:0]    V25_K   = NUM_W'(V25_K_INT);

  // captured request
  logic [RAW_W-1:0]          raw_temp_r, raw_ref_r;
  logic [stm_pkg::LOAD_W-1:0] load_r;
  logic                      zero_r;

  // products
  logic [P1_W-1:0]   p1_r;
  logic [DEN_W-1:0]  den_r;
  logic [SNUM_W-1:0] snum_r;
  logic [stm_pkg::SLOPE_W-1:0] slope_eff;
  logic signed [NUM_W-1:0] num;
  logic              num_neg_r;
  logic [MAG_W-1:0]  num_mag_r;

  // dividers
  logic             t_done, t_ovf, t_rnz;
  logic [QUO_W-1:0] t_quo;
  logic             s_done, s_ovf, s_rnz;
  logic [QUO_W-1:0] s_quo;

  // samples
  logic [TS_W-1:0]          t_mag;
  logic signed [TS_W-1:0]   t_q, t_sum;
  logic signed [TCUR_W-1:0] t_cur, t_cur_r;
  logic [SCUR_W-1:0]        s_cur, s_cur_r;
  logic [stm_pkg::LOAD_W-1:0] l_sat;
  logic [LCUR_W-1:0]        l_cur_r;

  // averages
  logic signed [TCUR_W-1:0] t_acc_r;
  logic [SCUR_W-1:0]        s_acc_r;
  logic [LCUR_W-1:0]        l_acc_r;

  logic signed [EMA_W-1:0] e_cur, e_acc, e_new;
  logic signed [EMA_W:0]   e_diff;
  logic signed [PROD_W-1:0] e_prod;
  logic signed [SUM_W-1:0]  e_sum;

  assign slope_eff = (cfg_slope == '0) ? stm_pkg::SLOPE_W'(1) : cfg_slope;
  assign num = $signed(NUM_W'(p1_r) * NUM_W'(10'd1000))
             - $signed(NUM_W'(cfg_v25) * V25_K);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_temp_r <= in_raw_temp;
      raw_ref_r  <= in_raw_ref;
      load_r     <= in_load_sample;
      zero_r     <= (in_raw_ref == '0);
    end
    if (cmd.mul1) begin
      p1_r   <= P1_W'(raw_temp_r) * P1_W'(cfg_aref);
      den_r  <= DEN_W'(slope_eff) * DEN_W'(ADC_MAX);
      snum_r <= (SNUM_W'(cfg_iref) * SNUM_W'(ADC_MAX)) << 8;
    end
    if (cmd.mul2) begin
      num_neg_r <= num[NUM_W-1];
      num_mag_r <= num[NUM_W-1] ? MAG_W'(-num) : MAG_W'(num);
    end
    if (cmd.sample) begin
      t_cur_r <= t_cur;
      s_cur_r <= s_cur;
      l_cur_r <= {l_sat, 8'h00};
    end
    if (cmd.load_out) begin
      out_temp_average      <= t_acc_r[TCUR_W-1:8];
      out_supply_average_mv <= s_acc_r[SCUR_W-1:8];
      out_load_average      <= l_acc_r[LCUR_W-1:8];
      out_ref_was_zero      <= zero_r;
    end
  end

  stm_div #(.VW(DEN_W), .QW(QUO_W)) u_tdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (TDIV_W'({num_mag_r, {stm_pkg::TFRAC{1'b0}}})),
    .divisor  (den_r),
    .done     (t_done),
    .ovf      (t_ovf),
    .rem_nz   (t_rnz),
    .quo      (t_quo)
  );

  stm_div #(.VW(RAW_W), .QW(QUO_W)) u_sdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (SDIV_W'(snum_r)),
    .divisor  (raw_ref_r),
    .done     (s_done),
    .ovf      (s_ovf),
    .rem_nz   (s_rnz),
    .quo      (s_quo)
  );

  assign stat.div_done = t_done & s_done;

  // floor division: negative numerators round away from zero
  always_comb begin
    t_mag = TS_W'(t_quo) + TS_W'(t_rnz);
    t_q   = num_neg_r ? $signed(-t_mag) : $signed(TS_W'(t_quo));
    t_sum = t_q + TS_W'(stm_pkg::TEMP_BIAS_Q16);
    if (t_ovf) begin
      t_cur = num_neg_r ? stm_pkg::TEMP_MIN_Q16 : stm_pkg::TEMP_MAX_Q16;
    end else if (t_sum < TS_W'(stm_pkg::TEMP_MIN_Q16)) begin
      t_cur = stm_pkg::TEMP_MIN_Q16;
    end else if (t_sum > TS_W'(stm_pkg::TEMP_MAX_Q16)) begin
      t_cur = stm_pkg::TEMP_MAX_Q16;
    end else begin
      t_cur = t_sum[TCUR_W-1:0];
    end
  end

  always_comb begin
    if (zero_r) begin
      s_cur = '0;
    end else if (s_ovf || (s_quo > SCUR_W'(stm_pkg::SUPPLY_MAX_Q8))) begin
      s_cur = stm_pkg::SUPPLY_MAX_Q8;
    end else begin
      s_cur = SCUR_W'(s_quo);
    end
    l_sat = (load_r > stm_pkg::LOAD_MAX_Q8) ? stm_pkg::LOAD_MAX_Q8 : load_r;
  end

  // acc + alpha*(cur - acc)/2^16, rounded half up
  always_comb begin
    unique case (cmd.ema_sel)
      stm_pkg::EMA_TEMP: begin
        e_cur = EMA_W'(t_cur_r);
        e_acc = EMA_W'(t_acc_r);
      end
      stm_pkg::EMA_SUP: begin
        e_cur = $signed(EMA_W'(s_cur_r));
        e_acc = $signed(EMA_W'(s_acc_r));
      end
      stm_pkg::EMA_LOAD: begin
        e_cur = $signed(EMA_W'(l_cur_r));
        e_acc = $signed(EMA_W'(l_acc_r));
      end
      default: begin
        e_cur = EMA_W'(t_cur_r);
        e_acc = EMA_W'(t_acc_r);
      end
    endcase
    e_diff = (EMA_W+1)'(e_cur) - (EMA_W+1)'(e_acc);
    e_prod = $signed({1'b0, cfg_alpha}) * e_diff;
    e_sum  = SUM_W'($signed({e_acc, {AL_W{1'b0}}})) + SUM_W'(e_prod)
           + $signed(SUM_W'(1) << (AL_W - 1));
    e_new  = e_sum[EMA_W+AL_W-1:AL_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_acc_r <= stm_pkg::TACC_RST;
      s_acc_r <= stm_pkg::SACC_RST;
      l_acc_r <= stm_pkg::LACC_RST;
    end else if (cmd.ema_en) begin
      unique case (cmd.ema_sel)
        stm_pkg::EMA_TEMP: t_acc_r <= e_new[TCUR_W-1:0];
        stm_pkg::EMA_SUP:  s_acc_r <= e_new[SCUR_W-1:0];
        stm_pkg::EMA_LOAD: l_acc_r <= e_new[LCUR_W-1:0];
        default:           t_acc_r <= t_acc_r;
      endcase
    end
  end

endmodule

### design/stm_ctrl.sv
// Sequencing FSM: request capture, multiply, divide, sample, smoothing, result handoff.
// Depends on stm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "supply_temperature_monitor_smoother_assert.svh"

module stm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output stm_pkg::ctrl_cmd_t cmd,
  input  stm_pkg::dp_stat_t  stat
);

  stm_pkg::ctrl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.ema_sel = stm_pkg::EMA_TEMP;
    unique case (state_r)
      stm_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = stm_pkg::ST_MUL1;
        end
      end
      stm_pkg::ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = stm_pkg::ST_MUL2;
      end
      stm_pkg::ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = stm_pkg::ST_DSTART;
      end
      stm_pkg::ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_nxt     = stm_pkg::ST_DIV;
      end
      stm_pkg::ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = stm_pkg::ST_SAMPLE;
        end
      end
      stm_pkg::ST_SAMPLE: begin
        cmd.sample = 1'b1;
        state_nxt  = stm_pkg::ST_EMA_T;
      end
      stm_pkg::ST_EMA_T: begin
        cmd.ema_en  = 1'b1;
        cmd.ema_sel = stm_pkg::EMA_TEMP;
        state_nxt   = stm_pkg::ST_EMA_S;
      end
      stm_pkg::ST_EMA_S: begin
        cmd.ema_en  = 1'b1;
        cmd.ema_sel = stm_pkg::EMA_SUP;
        state_nxt   = stm_pkg::ST_EMA_L;
      end
      stm_pkg::ST_EMA_L: begin
        cmd.ema_en  = 1'b1;
        cmd.ema_sel = stm_pkg::EMA_LOAD;
        state_nxt   = stm_pkg::ST_OUT;
      end
      stm_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = stm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = stm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // no request is taken while in reset
  assign in_stall  = !rst_n || (state_r != stm_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

  `STM_ASSERT_NEXT(a_accept_starts, clk, rst_n, (in_valid && !in_stall), (state_r == stm_pkg::ST_MUL1))
  `STM_ASSERT_NOW(a_load_when_free, clk, rst_n, cmd.load_out, (!out_valid_r || !out_stall))
  `STM_ASSERT_NEXT(a_div_restart, clk, rst_n, (state_r == stm_pkg::ST_DSTART), (state_r == stm_pkg::ST_DIV && !stat.div_done))
  `STM_ASSERT_NOW(a_valid_from_out, clk, rst_n, $rose(out_valid_r), ($past(state_r) == stm_pkg::ST_OUT))

endmodule

### tb/testbench.sv
// Self-checking testbench for supply_temperature_monitor_smoother.
// Needs stm_pkg and the monitor RTL; predicts every smoothed result and checks
// it while the request side idles and the result side stalls at random.
`timescale 1ns / 1ps

module testbench;

  localparam int ADC_BITS = 12;
  localparam longint ADC_MAX = (longint'(1) << ADC_BITS) - 1;
  localparam longint TEMP_LO_Q16 = -64'sd71424 * 256;
  localparam longint TEMP_HI_Q16 = 64'sd266496 * 256;
  localparam longint SUPPLY_CAP_Q8 = 64'sd4954950 * 256;
  localparam int LOAD_CAP_Q8 = 25600;
  localparam int RANDOM_ITEMS = 1920;
  localparam int RANDOM_PHASES = 8;
  localparam int CYCLE_LIMIT = 2000000;
  localparam logic [2:0] REG_UNUSED_LO = 3'd5;
  localparam logic [2:0] REG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic signed [stm_pkg::TEMP_OUT_W-1:0] temp_avg;
    logic [stm_pkg::SUP_OUT_W-1:0]         supply_mv;
    logic [stm_pkg::LOAD_W-1:0]            load_avg;
    logic                                  ref_zero;
  } averages_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [stm_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [stm_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [stm_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [stm_pkg::RAW_W-1:0] in_raw_temp = '0;
  logic [stm_pkg::RAW_W-1:0] in_raw_ref = '0;
  logic [stm_pkg::LOAD_W-1:0] in_load_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [stm_pkg::TEMP_OUT_W-1:0] out_temp_average;
  logic [stm_pkg::SUP_OUT_W-1:0] out_supply_average_mv;
  logic [stm_pkg::LOAD_W-1:0] out_load_average;
  logic out_ref_was_zero;

  // predictor copy of the registers and the averages
  int alpha_cfg = 13107;
  int aref_cfg = 3300;
  int v25_cfg = 760;
  int slope_cfg = 2500;
  int iref_cfg = 1210;
  int temp_acc = 1638400;
  longint supply_acc = 844800;
  longint load_acc = 655360;

  averages_t expected_averages[$];
  int mismatches = 0;
  int cycle_count = 0;
  bit no_idle = 1'b0;
  int stall_pct = 0;
  int stall_run = 0;
  int hold_len = 0;

  supply_temperature_monitor_smoother #(.ADC_BITS(ADC_BITS)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_raw_temp(in_raw_temp),
    .in_raw_ref(in_raw_ref),
    .in_load_sample(in_load_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_temp_average(out_temp_average),
    .out_supply_average_mv(out_supply_average_mv),
    .out_load_average(out_load_average),
    .out_ref_was_zero(out_ref_was_zero)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint floor_div(longint n, longint d);
    if (n >= 0) return n / d;
    return -(((-n) + d - 1) / d);
  endfunction

  function automatic averages_t predict_averages(logic [11:0] raw_t, logic [11:0] raw_r,
                                                 logic [14:0] load_in);
    longint a, slope, num, t_cur, t_sum, s_cur, l_cur, sv, lv;
    int tq;
    averages_t res;
    a = alpha_cfg;
    slope = (slope_cfg == 0) ? 1 : slope_cfg;
    num = longint'(raw_t) * aref_cfg * 1000 - longint'(v25_cfg) * 1000 * ADC_MAX;
    t_cur = floor_div(num * 65536, ADC_MAX * slope) + 25 * 65536;
    if (t_cur < TEMP_LO_Q16) t_cur = TEMP_LO_Q16;
    if (t_cur > TEMP_HI_Q16) t_cur = TEMP_HI_Q16;
    t_sum = a * t_cur + (65536 - a) * temp_acc + 32768;
    temp_acc = int'(t_sum >>> 16);

    s_cur = 0;
    if (raw_r != 0) begin
      s_cur = longint'(iref_cfg) * ADC_MAX * 256 / longint'(raw_r);
      if (s_cur > SUPPLY_CAP_Q8) s_cur = SUPPLY_CAP_Q8;
    end
    supply_acc = (a * s_cur + (65536 - a) * supply_acc + 32768) >> 16;

    l_cur = (load_in > LOAD_CAP_Q8) ? LOAD_CAP_Q8 : longint'(load_in);
    l_cur = l_cur * 256;
    load_acc = (a * l_cur + (65536 - a) * load_acc + 32768) >> 16;

    tq = temp_acc >>> 8;
    sv = supply_acc >> 8;
    lv = load_acc >> 8;
    res.temp_avg = tq[19:0];
    res.supply_mv = sv[22:0];
    res.load_avg = lv[14:0];
    res.ref_zero = (raw_r == 0);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      expected_averages.push_back(predict_averages(in_raw_temp, in_raw_ref, in_load_sample));
  end

  always @(posedge clk) begin
    averages_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_averages.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        mismatches++;
      end else begin
        exp_res = expected_averages.pop_front();
        if (out_temp_average !== exp_res.temp_avg) begin
          $display("%0t: temp_average expected %0d actual %0d",
                   $time, exp_res.temp_avg, out_temp_average);
          mismatches++;
        end
        if (out_supply_average_mv !== exp_res.supply_mv) begin
          $display("%0t: supply_average_mv expected %0d actual %0d",
                   $time, exp_res.supply_mv, out_supply_average_mv);
          mismatches++;
        end
        if (out_load_average !== exp_res.load_avg) begin
          $display("%0t: load_average expected %0d actual %0d",
                   $time, exp_res.load_avg, out_load_average);
          mismatches++;
        end
        if (out_ref_was_zero !== exp_res.ref_zero) begin
          $display("%0t: ref_was_zero expected %0b actual %0b",
                   $time, exp_res.ref_zero, out_ref_was_zero);
          mismatches++;
        end
      end
    end
  end

  // result side back-pressure; a forced hold-off takes priority
  always @(posedge clk) begin
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len = hold_len - 1;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run = stall_run - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_run = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 70) : $urandom_range(0, 3);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_sample(input logic [11:0] raw_t, input logic [11:0] raw_r,
                             input logic [14:0] load_in);
    int gap;
    in_valid <= 1'b1;
    in_raw_temp <= raw_t;
    in_raw_ref <= raw_r;
    in_load_sample <= load_in;
    do @(posedge clk); while (in_stall);
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_random_sample();
    logic [11:0] raw_t, raw_r;
    logic [14:0] load_in;
    int r;
    r = $urandom_range(0, 99);
    raw_t = (r < 10) ? ((r < 5) ? 12'd0 : 12'hFFF) : 12'($urandom_range(0, 4095));
    r = $urandom_range(0, 99);
    if (r < 8) raw_r = 12'd0;
    else if (r < 16) raw_r = 12'($urandom_range(1, 15));
    else raw_r = 12'($urandom_range(0, 4095));
    r = $urandom_range(0, 99);
    if (r < 5) load_in = 15'(LOAD_CAP_Q8);
    else if (r < 10) load_in = 15'h7FFF;
    else load_in = 15'($urandom_range(0, 32767));
    send_sample(raw_t, raw_r, load_in);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_averages.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      stm_pkg::REG_ALPHA: alpha_cfg = value[15:0];
      stm_pkg::REG_AREF:  aref_cfg = value[12:0];
      stm_pkg::REG_V25:   v25_cfg = value[10:0];
      stm_pkg::REG_SLOPE: slope_cfg = value[13:0];
      stm_pkg::REG_IREF:  iref_cfg = value[10:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(input int alpha, input int aref, input int v25, input int slope,
                           input int iref);
    write_reg(stm_pkg::REG_ALPHA, alpha);
    write_reg(stm_pkg::REG_AREF, aref);
    write_reg(stm_pkg::REG_V25, v25);
    write_reg(stm_pkg::REG_SLOPE, slope);
    write_reg(stm_pkg::REG_IREF, iref);
  endtask

  task automatic randomize_registers();
    int alpha, aref, v25, slope, iref;
    case ($urandom_range(0, 3))
      0: alpha = 0;
      1: alpha = 65535;
      2: alpha = 13107;
      default: alpha = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 3))
      0: aref = 1000;
      1: aref = 5000;
      default: aref = $urandom_range(1000, 5000);
    endcase
    case ($urandom_range(0, 3))
      0: v25 = 0;
      1: v25 = 2000;
      default: v25 = $urandom_range(0, 2000);
    endcase
    case ($urandom_range(0, 5))
      0: slope = 0;
      1: slope = 1;
      2: slope = 10000;
      default: slope = $urandom_range(1, 10000);
    endcase
    case ($urandom_range(0, 3))
      0: iref = 500;
      1: iref = 2000;
      default: iref = $urandom_range(500, 2000);
    endcase
    write_all(alpha, aref, v25, slope, iref);
  endtask

  task automatic test_default_extremes();
    send_sample(12'd0, 12'd0, 15'd0);
    send_sample(12'hFFF, 12'hFFF, 15'd25600);
    send_sample(12'hFFF, 12'd1, 15'h7FFF);
    send_sample(12'd0, 12'hFFF, 15'd0);
    send_sample(12'd2048, 12'd1500, 15'd12800);
    send_sample(12'hAAA, 12'h555, 15'h2AAA);
    send_sample(12'h555, 12'hAAA, 15'h5555);
  endtask

  task automatic test_register_extremes();
    wait_idle();
    write_all(65535, 5000, 0, 1, 2000);
    send_sample(12'hFFF, 12'd1, 15'd25600);
    send_sample(12'd0, 12'd2, 15'd0);
    send_sample(12'hFFF, 12'd0, 15'h7FFF);
    wait_idle();
    // alpha of zero freezes the averages; slope of zero acts as one
    write_all(0, 1000, 2000, 0, 500);
    send_sample(12'd0, 12'hFFF, 15'd25600);
    send_sample(12'hFFF, 12'd0, 15'd100);
    wait_idle();
    write_all(32768, 3300, 2000, 0, 1210);
    send_sample(12'd0, 12'd1, 15'd25601);
    send_sample(12'hFFF, 12'd3, 15'd1);
    wait_idle();
    write_reg(REG_UNUSED_LO, 32'd0);
    write_reg(REG_UNUSED_HI, 32'hFFFF_FFFF);
    write_all(40000, 3300, 760, 10000, 1210);
    send_sample(12'd1000, 12'd1500, 15'd5000);
    send_sample(12'd3000, 12'd0, 15'd20000);
    send_sample(12'd4000, 12'd4095, 15'd25599);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      randomize_registers();
      no_idle = (p == 3);
      if (no_idle) stall_pct = 0;
      else if (p % 3 == 0) stall_pct = 70;
      else if (p % 3 == 1) stall_pct = 25;
      else stall_pct = 10;
      repeat (RANDOM_ITEMS / RANDOM_PHASES) send_random_sample();
    end
  endtask

  task automatic test_result_hold_off();
    wait_idle();
    no_idle = 1'b1;
    stall_pct = 0;
    hold_len = 800;
    repeat (40) send_random_sample();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_extremes();
    test_register_extremes();
    test_random_phases();
    test_result_hold_off();
    wait_idle();
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
